FILE: hdl/tmtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared constants, command and result types of the text-mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int TOTAL   = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CUR_W  = $clog2(TOTAL + COLUMNS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam int TAB_SPACES = 5;
    localparam int TAB_W      = $clog2(TAB_SPACES + 1);

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {DEFAULT_ATTR, CH_SPACE};

    typedef enum logic [2:0] {
        OP_READ,
        OP_BACKSPACE,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CHAR
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CHECK,
        S_COPY,
        S_BLANK,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } res_t;

endpackage

FILE: hdl/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text-mode character cell engine with cursor, control codes and scrolling.
// ----------------------------------------------------------------------------
// After reset the block blanks all 2000 cells (one per cycle) with s_tready
// held low; then it takes request items. A front stage classifies each item
// into a command and pushes it into a two-entry queue; a back stage executes
// commands one at a time on a single-port-write, registered-read cell memory.
// A read steps through EXEC, READ and FINISH; a put or control code through
// EXEC, CHECK and FINISH, and a tab repeats EXEC and CHECK for each space.
// Any put that moves the cursor past the last cell scrolls: the memory sweep
// copies TOTAL-COLUMNS cells through the one read and one write port and
// blanks the bottom row. The result register lets the back stage take and
// execute the next item while the previous result still waits on m_tready.
module text_mode_terminal_writer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_pos[10:0], cell_data[26:11]
    output logic [0:0]  m_tuser    // scrolled[0]
);
    import tmtw_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    res_t result;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    logic clearing;

    // classify request items
    tmtw_front u_front
    (
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .req_type   (s_tuser[0]),
        .char_code  (s_tdata[7:0]),
        .attribute  (s_tdata[15:8]),
        .cell_index (s_tdata[26:16]),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (front_cmd)
    );

    // decouple front and back
    tmtw_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .valid    (q_valid),
        .full     (q_full),
        .head     (head_cmd)
    );

    // execute commands on the cell store
    tmtw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .clearing  (clearing),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (result)
    );

    // pack result fields, pad tdata to whole bytes
    assign m_tdata = {5'd0, result.cell_data, result.cursor_pos};
    assign m_tuser = result.scrolled;

endmodule

FILE: hdl/tmtw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_front
// Accept request items and classify them into commands for the queue.
// ----------------------------------------------------------------------------
module tmtw_front
(
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      req_type,
    input  logic [7:0]                char_code,
    input  logic [7:0]                attribute,
    input  logic [10:0]               cell_index,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      push,
    output tmtw_pkg::cmd_t            cmd
);
    import tmtw_pkg::*;

    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    always_comb
    begin
        cmd.ch    = char_code;
        cmd.index = cell_index;
        // zero attribute selects the default
        cmd.attr  = (attribute == '0) ? DEFAULT_ATTR : attribute;
        priority if (req_type)
        begin
            cmd.op = OP_READ;
        end
        else if (char_code == CH_BACKSPACE)
        begin
            cmd.op = OP_BACKSPACE;
        end
        else if (char_code == CH_TAB)
        begin
            cmd.op = OP_TAB;
        end
        else if (char_code == CH_NEWLINE)
        begin
            cmd.op = OP_NEWLINE;
        end
        else if (char_code == CH_RETURN)
        begin
            cmd.op = OP_RETURN;
        end
        else
        begin
            cmd.op = OP_CHAR;
        end
    end

endmodule

FILE: hdl/tmtw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tmtw_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmtw_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           valid,
    output logic           full,
    output tmtw_pkg::cmd_t head
);
    import tmtw_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/tmtw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtw_back
// Execute commands on the cell store and cursor; scroll and clear by sweeps.
// ----------------------------------------------------------------------------
module tmtw_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  tmtw_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           clearing,
    output logic           res_valid,
    input  logic           res_ready,
    output tmtw_pkg::res_t res
);
    import tmtw_pkg::*;

    logic [CELL_W-1:0] mem [TOTAL];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [TAB_W-1:0]  tab_cnt_reg, tab_cnt_next;
    logic              scrolled_reg, scrolled_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic              tab_more;
    logic              in_range;

    assign clearing  = (state_reg == S_CLEAR);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign tab_more  = (cmd_reg.op == OP_TAB) && (tab_cnt_reg != TAB_W'(TAB_SPACES));
    assign in_range  = (32'(cmd_reg.index) < 32'(TOTAL));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        tab_cnt_next   = tab_cnt_reg;
        scrolled_next  = scrolled_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(cursor_reg);
        mem_wdata      = BLANK_CELL;
        mem_raddr      = ADDR_W'(cmd_reg.index);

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    tab_cnt_next  = '0;
                    scrolled_next = 1'b0;
                    data_next     = '0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_CHECK;
                unique case (cmd_reg.op)
                    OP_READ:
                    begin
                        state_next = S_READ;
                    end
                    OP_BACKSPACE:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = ADDR_W'(cursor_reg - 1'b1);
                            mem_wdata   = {cmd_reg.attr, CH_SPACE};
                        end
                    end
                    OP_NEWLINE:
                    begin
                        cursor_next = cursor_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS);
                        col_next    = '0;
                    end
                    OP_RETURN:
                    begin
                        cursor_next = cursor_reg - CUR_W'(col_reg);
                        col_next    = '0;
                    end
                    OP_TAB, OP_CHAR:
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = (cmd_reg.op == OP_TAB) ? BLANK_CELL
                                                              : {cmd_reg.attr, cmd_reg.ch};
                        tab_cnt_next = tab_cnt_reg + 1'b1;
                        cursor_next  = cursor_reg + 1'b1;
                        col_next     = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                    end
                    default:
                    begin
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_READ:
            begin
                data_next  = in_range ? rdata_reg : '0;
                state_next = S_FINISH;
            end
            S_CHECK:
            begin
                priority if (cursor_reg >= CUR_W'(TOTAL))
                begin
                    scrolled_next = 1'b1;
                    cursor_next   = cursor_reg - CUR_W'(COLUMNS);
                    cnt_next      = '0;
                    state_next    = S_COPY;
                end
                else if (tab_more)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_COPY:
            begin
                // read one row ahead, write the cell read in the previous cycle
                mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - 1'b1;
                    mem_wdata = rdata_reg;
                end
                if (cnt_reg == ADDR_W'(TOTAL - COLUMNS))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(TOTAL - 1))
                begin
                    state_next = tab_more ? S_EXEC : S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.cursor_pos = IDX_W'(cursor_reg);
                    out_next.cell_data  = data_reg;
                    out_next.scrolled   = scrolled_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            tab_cnt_reg   <= '0;
            scrolled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            tab_cnt_reg   <= tab_cnt_next;
            scrolled_reg  <= scrolled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text-mode terminal writer. A short table of
// directed requests (reads after reset, out-of-screen reads, backspace at the
// home cell, attribute defaulting, byte zero, tab, return, newline) runs
// first. Then comes a random stream of text lines, newline bursts that force
// scrolling, long lines that wrap, and stray control bytes. Every result is
// compared field by field to a local model of the screen and cursor, or to
// a typed-in result for table rows so marked. Both handshake sides idle in
// random bursts; the receiver holds off once so long that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    import tmtw_pkg::*;

    // Request kinds carried in s_tuser, and where an expectation comes from
    localparam bit REQ_PUT    = 1'b0;
    localparam bit REQ_READ   = 1'b1;
    localparam bit FROM_MODEL = 1'b0;
    localparam bit FROM_TABLE = 1'b1;

    localparam int RANDOM_ITEMS   = 400;
    localparam int CALM_ITEMS     = 60;      // tail of the run with no idling
    localparam int HOLD_AT        = 150;     // results seen before the long hold-off
    localparam int HOLD_CYCLES    = 5000;
    localparam int DRAIN_CYCLES   = 2100;    // covers one full scroll sweep
    localparam int WATCHDOG_LIMIT = 30000;   // cycles with no item moving
    localparam int DIR_ROWS       = 23;
    localparam int READ_SPAN      = 2048;    // every code of cell_index

    typedef struct packed {
        logic              req;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [IDX_W-1:0]  idx;
        logic              mode;
        res_t              want;
    } request_row_t;

    localparam res_t NO_RES = '0;

    // Directed requests; typed-in results only where they are obvious
    localparam request_row_t DIRECTED [DIR_ROWS] = '{
        // fresh screen: blanks everywhere, nothing past the last cell
        '{REQ_READ, 8'h00, 8'h00, 11'd0,    FROM_TABLE, '{11'd0, BLANK_CELL, 1'b0}},
        '{REQ_READ, 8'hff, 8'hff, 11'd1999, FROM_TABLE, '{11'd0, BLANK_CELL, 1'b0}},
        '{REQ_READ, 8'h00, 8'h00, 11'd2047, FROM_TABLE, '{11'd0, 16'h0000, 1'b0}},
        '{REQ_READ, 8'h00, 8'h00, 11'd2000, FROM_TABLE, '{11'd0, 16'h0000, 1'b0}},
        // backspace at the home cell leaves everything alone
        '{REQ_PUT, CH_BACKSPACE, 8'h5a, 11'd0, FROM_TABLE, '{11'd0, 16'h0000, 1'b0}},
        // zero attribute falls back to the default
        '{REQ_PUT,  8'h41, 8'h00, 11'd2047, FROM_TABLE, '{11'd1, 16'h0000, 1'b0}},
        '{REQ_READ, 8'h00, 8'h00, 11'd0,    FROM_TABLE, '{11'd1, 16'h0741, 1'b0}},
        '{REQ_PUT,  8'hff, 8'hff, 11'd0,    FROM_TABLE, '{11'd2, 16'h0000, 1'b0}},
        '{REQ_READ, 8'h00, 8'h00, 11'd1,    FROM_TABLE, '{11'd2, 16'hffff, 1'b0}},
        // byte zero is stored like any character
        '{REQ_PUT,  8'h00, 8'h80, 11'd0,    FROM_TABLE, '{11'd3, 16'h0000, 1'b0}},
        '{REQ_READ, 8'h00, 8'h00, 11'd2,    FROM_TABLE, '{11'd3, 16'h8000, 1'b0}},
        '{REQ_PUT,  CH_BACKSPACE, 8'h3c, 11'd0, FROM_MODEL, NO_RES},
        '{REQ_READ, 8'h00, 8'h00, 11'd2,        FROM_MODEL, NO_RES},
        // tab writes default-attribute spaces whatever attribute comes in
        '{REQ_PUT,  CH_TAB, 8'hee, 11'd0,       FROM_MODEL, NO_RES},
        '{REQ_READ, 8'h00, 8'h00, 11'd6,        FROM_MODEL, NO_RES},
        '{REQ_PUT,  CH_RETURN, 8'h11, 11'd0,    FROM_MODEL, NO_RES},
        '{REQ_PUT,  CH_NEWLINE, 8'h22, 11'd0,   FROM_MODEL, NO_RES},
        // other control bytes are stored, not interpreted
        '{REQ_PUT,  8'h1b, 8'h01, 11'd0,        FROM_MODEL, NO_RES},
        '{REQ_READ, 8'h00, 8'h00, 11'd80,       FROM_MODEL, NO_RES},
        // backspace twice: the second one crosses back into the row above
        '{REQ_PUT,  CH_BACKSPACE, 8'h00, 11'd0, FROM_MODEL, NO_RES},
        '{REQ_PUT,  CH_BACKSPACE, 8'h00, 11'd0, FROM_MODEL, NO_RES},
        '{REQ_READ, 8'h00, 8'h00, 11'd79,       FROM_MODEL, NO_RES},
        '{REQ_PUT,  8'h7f, 8'h9c, 11'd1024,     FROM_MODEL, NO_RES}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // char_code[7:0], attribute[15:8], cell_index[26:16]
    logic [0:0]  s_tuser  = '0;   // req_type[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // cursor_pos[10:0], cell_data[26:11]
    logic [0:0]  m_tuser;         // scrolled[0]

    // Side data that travels with the offered item, for table rows
    bit   row_mode = FROM_MODEL;
    res_t row_want = '0;

    // Local copy of the screen and cursor
    logic [CELL_W-1:0] term_cells [TOTAL];
    int                term_cursor;

    res_t pending_results [$];

    int  requests_in   = 0;
    int  reads_in      = 0;
    int  results_out   = 0;
    int  scrolls_seen  = 0;
    int  mismatches    = 0;
    int  idle_cycles   = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    bit  calm          = 1'b0;

    text_mode_terminal_writer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Write one cell at the cursor and advance.
    function automatic void store_cell(input logic [ATTR_W-1:0] attr_hi,
                                       input logic [CHAR_W-1:0] ch);
        term_cells[term_cursor] = {attr_hi, ch};
        term_cursor++;
    endfunction

    // Scroll up one row once the cursor runs off the end of the screen.
    function automatic bit scroll_if_past_end();
        if (term_cursor < TOTAL)
            return 1'b0;
        for (int i = 0; i < TOTAL - COLUMNS; i++)
            term_cells[i] = term_cells[i + COLUMNS];
        for (int i = TOTAL - COLUMNS; i < TOTAL; i++)
            term_cells[i] = BLANK_CELL;
        term_cursor -= COLUMNS;
        return 1'b1;
    endfunction

    // Apply one request to the local screen and return the result it causes.
    function automatic res_t screen_update(input logic req, input logic [CHAR_W-1:0] ch,
                                           input logic [ATTR_W-1:0] attr,
                                           input logic [IDX_W-1:0] idx);
        res_t              r;
        op_t               op;
        logic [ATTR_W-1:0] attr_hi;
        r = '0;
        if (term_cursor >= TOTAL)
            term_cursor = 0;
        if (req == REQ_READ)
            op = OP_READ;
        else
        begin
            case (ch)
                CH_BACKSPACE: op = OP_BACKSPACE;
                CH_NEWLINE:   op = OP_NEWLINE;
                CH_RETURN:    op = OP_RETURN;
                CH_TAB:       op = OP_TAB;
                default:      op = OP_CHAR;
            endcase
        end
        attr_hi = (attr == '0) ? DEFAULT_ATTR : attr;
        case (op)
            OP_READ:
            begin
                if (idx < TOTAL)
                    r.cell_data = term_cells[idx];
            end
            OP_BACKSPACE:
            begin
                if (term_cursor > 0)
                begin
                    term_cursor--;
                    term_cells[term_cursor] = {attr_hi, CH_SPACE};
                end
            end
            OP_NEWLINE: term_cursor = (term_cursor / COLUMNS + 1) * COLUMNS;
            OP_RETURN:  term_cursor = term_cursor - term_cursor % COLUMNS;
            OP_TAB:
            begin
                // each space may scroll; report whether any did
                for (int k = 0; k < TAB_SPACES; k++)
                begin
                    store_cell(DEFAULT_ATTR, CH_SPACE);
                    if (scroll_if_past_end())
                        r.scrolled = 1'b1;
                end
            end
            default: store_cell(attr_hi, ch);
        endcase
        if (op != OP_READ && scroll_if_past_end())
            r.scrolled = 1'b1;
        r.cursor_pos = term_cursor[IDX_W-1:0];
        return r;
    endfunction

    // Sample both handshakes at the edge: predict on input, check on output.
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        bit   moved;
        moved = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            want = screen_update(s_tuser[0], s_tdata[CHAR_W-1:0],
                                 s_tdata[CHAR_W+ATTR_W-1:CHAR_W],
                                 s_tdata[CHAR_W+ATTR_W+IDX_W-1:CHAR_W+ATTR_W]);
            if (row_mode == FROM_TABLE)
                want = row_want;
            pending_results.push_back(want);
            requests_in++;
            if (s_tuser[0] == REQ_READ)
                reads_in++;
            moved = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cursor_pos = m_tdata[IDX_W-1:0];
            got.cell_data  = m_tdata[IDX_W+CELL_W-1:IDX_W];
            got.scrolled   = m_tuser[0];
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: cursor_pos %0d, cell_data 0x%04h",
                       got.cursor_pos, got.cell_data);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cursor_pos !== want.cursor_pos)
                begin
                    $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
                    mismatches++;
                end
                if (got.cell_data !== want.cell_data)
                begin
                    $error("cell_data: expected 0x%04h, got 0x%04h",
                           want.cell_data, got.cell_data);
                    mismatches++;
                end
                if (got.scrolled !== want.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                    mismatches++;
                end
            end
            if (got.scrolled === 1'b1)
                scrolls_seen++;
            results_out++;
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Receiver: random stall bursts, one long hold-off, none in the tail.
    initial
    begin : receiver
        int run_len;
        bit ready_lvl;
        run_len   = 0;
        ready_lvl = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_out >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
            begin
                if (run_len == 0)
                begin
                    if ($urandom_range(0, 9) < 4)
                    begin
                        ready_lvl = 1'b0;
                        run_len   = $urandom_range(1, 18);
                    end
                    else
                    begin
                        ready_lvl = 1'b1;
                        run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                : $urandom_range(1, 30);
                    end
                end
                run_len--;
                m_tready <= ready_lvl;
            end
        end
    end

    // Present one request item and hold it until the block takes it.
    task automatic offer(input request_row_t row);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, row.idx, row.attr, row.ch};
        s_tuser  <= row.req;
        row_mode <= row.mode;
        row_want <= row.want;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Sender: drop valid for a random burst now and then, never during the
    // long hold-off or the calm tail.
    task automatic sender_gap(input int gap_pct);
        if (!calm && hold_left == 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: %0d cycles with no item moving", WATCHDOG_LIMIT);
        $display("** text_mode_terminal_writer: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        request_row_t row;
        int           gap_pct;
        int           nl_burst;
        int           long_run;
        int           pick;
        nl_burst = 0;
        long_run = 0;
        gap_pct  = 35;

        // the block comes out of reset with a blank screen and the cursor home
        foreach (term_cells[i])
            term_cells[i] = BLANK_CELL;
        term_cursor = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            offer(DIRECTED[i]);
            sender_gap(gap_pct);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n % 40 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;

            row.req  = REQ_PUT;
            row.mode = FROM_MODEL;
            row.want = NO_RES;
            row.idx  = 11'($urandom_range(0, READ_SPAN - 1));
            row.attr = ($urandom_range(0, 99) < 15) ? 8'h00 : 8'($urandom_range(0, 255));
            row.ch   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7e))
                                                   : 8'($urandom_range(0, 255));

            // newline bursts push the cursor to the bottom so scrolls follow;
            // long lines wrap through the end of a row
            if (nl_burst > 0)
            begin
                nl_burst--;
                row.ch = CH_NEWLINE;
            end
            else if (long_run > 0)
            begin
                long_run--;
                if ($urandom_range(0, 19) == 0)
                    row.ch = CH_TAB;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    nl_burst = $urandom_range(3, 12);
                    row.ch   = CH_NEWLINE;
                end
                else if (pick < 5)
                    long_run = $urandom_range(40, 90);
                else if (pick < 25)
                begin
                    row.req = REQ_READ;
                    row.ch  = 8'($urandom_range(0, 255));
                    row.idx = ($urandom_range(0, 99) < 12) ? 11'($urandom_range(TOTAL, 2047))
                                                           : 11'($urandom_range(0, TOTAL - 1));
                end
                else if (pick < 37)
                    row.ch = CH_NEWLINE;
                else if (pick < 42)
                    row.ch = CH_RETURN;
                else if (pick < 48)
                    row.ch = CH_BACKSPACE;
                else if (pick < 54)
                    row.ch = CH_TAB;
            end
            offer(row);
            sender_gap(gap_pct);
        end
        s_tvalid <= 1'b0;

        // Hold until every result is back, then let any stray one show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("Run covered %0d requests (%0d cell reads) and %0d results, %0d of them scrolled.",
                 requests_in, reads_in, results_out, scrolls_seen);
        $display("Random stalls on both sides plus one %0d-cycle receiver hold-off were applied.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("** text_mode_terminal_writer: PASSED **");
        else
            $display("** text_mode_terminal_writer: FAILED **");
        $finish;
    end

endmodule
